/* hw/rtl/rvc_pkg.sv */
package rvc_pkg;

    // Default number format: Q8.16 in a 24-bit word.
    localparam int DATA_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_SOURCE_GAIN_REAL        = 3'd0;
    localparam t_cfg_index CFG_SOURCE_GAIN_IMAG        = 3'd1;
    localparam t_cfg_index CFG_CURRENT_GAIN            = 3'd2;
    localparam t_cfg_index CFG_LEAKAGE_REACTANCE       = 3'd3;
    localparam t_cfg_index CFG_COMMUTATION_FACTOR_GAIN = 3'd4;
    localparam t_cfg_index CFG_BRIDGE_VOLTAGE_LIMIT    = 3'd5;

    // Segment of the commutation factor curve that applies to an item.
    typedef enum logic [2:0] {
        SEG_ONE,
        SEG_LINEAR,
        SEG_ROOT,
        SEG_FALL,
        SEG_ZERO
    } t_fex_seg;

endpackage

/* hw/rtl/rvc_sqrt.sv */
module rvc_sqrt #(
    parameter int IN_W  = 48,
    parameter int PAY_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [IN_W-1:0]    i_value,
    input  logic [PAY_W-1:0]   i_payload,
    output logic               o_valid,
    output logic [IN_W/2-1:0]  o_root,
    output logic [PAY_W-1:0]   o_payload
);

    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 3;

    logic [RW-1:0]    r_rem  [OUT_W];
    logic [OUT_W-1:0] r_root [OUT_W];
    logic [IN_W-1:0]  r_val  [OUT_W];
    logic [PAY_W-1:0] r_pay  [OUT_W];
    logic             r_vld  [OUT_W];

    // One result bit per stage, two radicand bits brought down each time.
    for (genvar k = 0; k < OUT_W; k++) begin : g_step
        logic [RW-1:0]    w_rem_in;
        logic [OUT_W-1:0] w_root_in;
        logic [IN_W-1:0]  w_val_in;
        logic [PAY_W-1:0] w_pay_in;
        logic             w_vld_in;
        logic [RW-1:0]    w_shift;
        logic [RW-1:0]    w_trial;
        logic [RW-1:0]    n_rem;
        logic [OUT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_val_in  = i_value;
            assign w_pay_in  = i_payload;
            assign w_vld_in  = i_valid;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_val_in  = r_val[k-1];
            assign w_pay_in  = r_pay[k-1];
            assign w_vld_in  = r_vld[k-1];
        end

        assign w_shift = {w_rem_in[RW-3:0], w_val_in[IN_W-1 -: 2]};
        assign w_trial = RW'({w_root_in, 2'b01});

        always_comb begin
            if (w_shift >= w_trial) begin
                n_rem  = w_shift - w_trial;
                n_root = {w_root_in[OUT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_shift;
                n_root = {w_root_in[OUT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld_in;
            end
            r_rem[k]  <= n_rem;
            r_root[k] <= n_root;
            r_val[k]  <= w_val_in << 2;
            r_pay[k]  <= w_pay_in;
        end
    end

    // Round to nearest: the remainder exceeds the root exactly when the
    // true root lies above root + 1/2.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld[OUT_W-1];
        end
        if (r_rem[OUT_W-1] > RW'(r_root[OUT_W-1])) begin
            o_root <= r_root[OUT_W-1] + 1'b1;
        end else begin
            o_root <= r_root[OUT_W-1];
        end
        o_payload <= r_pay[OUT_W-1];
    end

endmodule

/* hw/rtl/rvc_div.sv */
module rvc_div #(
    parameter int QW    = 24,
    parameter int DW    = 23,
    parameter int PAY_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [QW+DW-1:0]   i_num,
    input  logic [DW-1:0]      i_den,
    input  logic [PAY_W-1:0]   i_payload,
    output logic               o_valid,
    output logic [QW-1:0]      o_quotient,
    output logic [PAY_W-1:0]   o_payload
);

    logic [DW-1:0]    r_rem [QW];
    logic [QW-1:0]    r_low [QW];
    logic [QW-1:0]    r_quo [QW];
    logic [DW-1:0]    r_den [QW];
    logic [PAY_W-1:0] r_pay [QW];
    logic             r_vld [QW];

    // Restoring division, one quotient bit per stage. The upper part of the
    // numerator must be below the divisor; the caller flags the other case.
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW-1:0]    w_rem_in;
        logic [QW-1:0]    w_low_in;
        logic [QW-1:0]    w_quo_in;
        logic [DW-1:0]    w_den_in;
        logic [PAY_W-1:0] w_pay_in;
        logic             w_vld_in;
        logic [DW:0]      w_shift;
        logic [DW-1:0]    n_rem;
        logic [QW-1:0]    n_quo;

        if (k == 0) begin : g_first
            assign w_rem_in = i_num[QW+DW-1:QW];
            assign w_low_in = i_num[QW-1:0];
            assign w_quo_in = '0;
            assign w_den_in = i_den;
            assign w_pay_in = i_payload;
            assign w_vld_in = i_valid;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_low_in = r_low[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_den_in = r_den[k-1];
            assign w_pay_in = r_pay[k-1];
            assign w_vld_in = r_vld[k-1];
        end

        assign w_shift = {w_rem_in, w_low_in[QW-1]};

        always_comb begin
            if (w_shift >= {1'b0, w_den_in}) begin
                n_rem = DW'(w_shift - {1'b0, w_den_in});
                n_quo = {w_quo_in[QW-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DW-1:0];
                n_quo = {w_quo_in[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld_in;
            end
            r_rem[k] <= n_rem;
            r_low[k] <= w_low_in << 1;
            r_quo[k] <= n_quo;
            r_den[k] <= w_den_in;
            r_pay[k] <= w_pay_in;
        end
    end

    assign o_valid    = r_vld[QW-1];
    assign o_quotient = r_quo[QW-1];
    assign o_payload  = r_pay[QW-1];

endmodule

/* hw/rtl/rectifier_voltage_commutation.sv */
// Rectifier voltage with commutation loading, Q8.16 by default, fully
// pipelined: one item may be started in every clock cycle (busy is always
// low) and its result appears later, marked by o_done for exactly one cycle.
// Most of the depth lies in the two bit-per-stage square root pipelines and
// the bit-per-stage divider. The receiver cannot stall the block, so every
// result must be taken in the cycle it is shown. Configuration writes take
// effect fully for items started in the cycle after the write or later;
// items already in flight may see part of the new settings.
module rectifier_voltage_commutation #(
    parameter int DATA_WIDTH = rvc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rvc_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    output logic                        o_done,
    input  logic                        i_cfg_we,
    input  rvc_pkg::t_cfg_index         i_cfg_index,
    input  logic [DATA_WIDTH-1:0]       i_cfg_data,
    input  logic signed [DATA_WIDTH-1:0] i_voltage_direct,
    input  logic signed [DATA_WIDTH-1:0] i_voltage_quadrature,
    input  logic signed [DATA_WIDTH-1:0] i_current_direct,
    input  logic signed [DATA_WIDTH-1:0] i_current_quadrature,
    input  logic signed [DATA_WIDTH-1:0] i_field_current,
    input  logic signed [DATA_WIDTH-1:0] i_inner_regulator_output,
    output logic [DATA_WIDTH-2:0]       o_source_voltage,
    output logic                        o_source_floored,
    output logic signed [DATA_WIDTH-1:0] o_normalized_load_current,
    output logic [FRAC_BITS:0]          o_commutation_factor,
    output logic [DATA_WIDTH-2:0]       o_bridge_voltage,
    output logic signed [DATA_WIDTH-1:0] o_field_voltage
);

    import rvc_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int KXW  = 2 * W - F;        // rounded KPC*XL terms
    localparam int KEW  = KXW + 1;          // KI + KPC_re*XL
    localparam int MW   = KEW + W;          // widest product
    localparam int SUMW = MW + 2;           // four-term sum
    localparam int RW   = SUMW - F;         // rounded VE parts

    localparam longint unsigned C0433_L = ((64'd433 << F) + 64'd500) / 64'd1000;
    localparam longint unsigned C0577_L = ((64'd577 << F) + 64'd500) / 64'd1000;
    localparam longint unsigned C075_L  = (64'd3 << F) / 64'd4;
    localparam longint unsigned C1732_L = ((64'd1732 << F) + 64'd500) / 64'd1000;

    localparam logic [F-1:0] C_0433 = F'(C0433_L);
    localparam logic [F-1:0] C_0577 = F'(C0577_L);
    localparam logic [F-1:0] C_075  = F'(C075_L);
    localparam logic [F:0]   C_1732 = (F+1)'(C1732_L);
    localparam logic [F:0]   FEX_ONE = (F+1)'(1) << F;

    localparam logic [W-2:0]        SMAX_U = '1;
    localparam logic signed [W-1:0] SMAX_S = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN_S = {1'b1, {(W-1){1'b0}}};

    localparam logic signed [W-1:0] KR_RESET    = W'(1) << F;
    localparam logic [W-2:0]        VBMAX_RESET = (W-1)'(10) << F;

    // Rounding offsets (one half LSB of the result) for each product width.
    localparam logic signed [2*W-1:0]  HALF_2W  = (2*W)'(1) << (F-1);
    localparam logic signed [SUMW-1:0] HALF_SUM = SUMW'(1) << (F-1);
    localparam logic [2*F-1:0]         HALF_2F  = (2*F)'(1) << (F-1);
    localparam logic [2*F+1:0]         HALF_2F2 = (2*F+2)'(1) << (F-1);
    localparam logic [W+F-1:0]         HALF_WF  = (W+F)'(1) << (F-1);

    // Side data carried alongside the long arithmetic pipelines.
    typedef struct packed {
        logic                 over;
        logic                 sign;
        logic [2*W-3:0]       mag;
        logic signed [W-1:0]  vm;
    } t_pay_root;

    typedef struct packed {
        logic [W-2:0]         ve;
        logic                 fl;
        logic                 sign;
        logic                 ovf;
        logic signed [W-1:0]  vm;
    } t_pay_div;

    typedef struct packed {
        t_fex_seg             seg;
        logic [F:0]           lin;
        logic [F:0]           fall;
        logic [W-2:0]         ve;
        logic                 fl;
        logic signed [W-1:0]  inl;
        logic signed [W-1:0]  vm;
    } t_pay_fex;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [W-1:0] r_kr;
    logic signed [W-1:0] r_ki;
    logic signed [W-1:0] r_kig;
    logic signed [W-1:0] r_xl;
    logic [W-2:0]        r_kc;
    logic [W-2:0]        r_vbmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kr    <= KR_RESET;
            r_ki    <= '0;
            r_kig   <= '0;
            r_xl    <= '0;
            r_kc    <= '0;
            r_vbmax <= VBMAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOURCE_GAIN_REAL:        r_kr    <= i_cfg_data;
                CFG_SOURCE_GAIN_IMAG:        r_ki    <= i_cfg_data;
                CFG_CURRENT_GAIN:            r_kig   <= i_cfg_data;
                CFG_LEAKAGE_REACTANCE:       r_xl    <= i_cfg_data;
                CFG_COMMUTATION_FACTOR_GAIN: r_kc    <= i_cfg_data[W-2:0];
                CFG_BRIDGE_VOLTAGE_LIMIT:    r_vbmax <= i_cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // The reactance terms depend on configuration only. They pass through a
    // product register and then a rounding register, and settle before an item
    // started after that write reaches the products stage.
    logic signed [2*W-1:0] r_kxp_re;
    logic signed [2*W-1:0] r_kxp_im;
    logic signed [KEW-1:0] r_keff;
    logic signed [KXW-1:0] r_kxim;
    logic signed [2*W-1:0] w_kxr_re;
    logic signed [2*W-1:0] w_kxr_im;

    assign w_kxr_re = r_kxp_re + HALF_2W;
    assign w_kxr_im = r_kxp_im + HALF_2W;

    always_ff @(posedge i_clk) begin
        r_kxp_re <= r_kr * r_xl;
        r_kxp_im <= r_ki * r_xl;
        r_keff   <= KEW'(r_kig) + KEW'($signed(w_kxr_re[2*W-1:F]));
        r_kxim   <= $signed(w_kxr_im[2*W-1:F]);
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stages 1 and 2: input capture and a delay stage
    // ------------------------------------------------------------------
    logic                r1_vld, r2_vld;
    logic signed [W-1:0] r1_vd, r1_vq, r1_id, r1_iq, r1_ifd, r1_vm;
    logic signed [W-1:0] r2_vd, r2_vq, r2_id, r2_iq, r2_ifd, r2_vm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= start;
            r2_vld <= r1_vld;
        end
        r1_vd  <= i_voltage_direct;
        r1_vq  <= i_voltage_quadrature;
        r1_id  <= i_current_direct;
        r1_iq  <= i_current_quadrature;
        r1_ifd <= i_field_current;
        r1_vm  <= i_inner_regulator_output;
        r2_vd  <= r1_vd;
        r2_vq  <= r1_vq;
        r2_id  <= r1_id;
        r2_iq  <= r1_iq;
        r2_ifd <= r1_ifd;
        r2_vm  <= r1_vm;
    end

    // ------------------------------------------------------------------
    // Stage 3: the products of the compound source phasor
    // ------------------------------------------------------------------
    logic                  r3_vld;
    logic signed [MW-1:0]  r3_a, r3_b, r3_c, r3_d, r3_e, r3_f, r3_g, r3_h;
    logic signed [2*W-1:0] r3_p;
    logic signed [W-1:0]   r3_vm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_a  <= r_kr * r2_vd;
        r3_b  <= r_ki * r2_vq;
        r3_c  <= r_keff * r2_iq;
        r3_d  <= r_kxim * r2_id;
        r3_e  <= r_ki * r2_vd;
        r3_f  <= r_kr * r2_vq;
        r3_g  <= r_keff * r2_id;
        r3_h  <= r_kxim * r2_iq;
        r3_p  <= $signed({1'b0, r_kc}) * r2_ifd;
        r3_vm <= r2_vm;
    end

    // ------------------------------------------------------------------
    // Stage 4: real and imaginary parts, rounded; magnitude of KC*Ifd
    // ------------------------------------------------------------------
    logic                  r4_vld;
    logic signed [RW-1:0]  r4_re, r4_im;
    logic                  r4_sign;
    logic [2*W-3:0]        r4_mag;
    logic signed [W-1:0]   r4_vm;
    logic signed [SUMW-1:0] w_re_sum, w_im_sum;
    logic signed [2*W-1:0] w_pabs;

    assign w_re_sum = SUMW'(r3_a) - SUMW'(r3_b) - SUMW'(r3_c) - SUMW'(r3_d) + HALF_SUM;
    assign w_im_sum = SUMW'(r3_e) + SUMW'(r3_f) + SUMW'(r3_g) - SUMW'(r3_h) + HALF_SUM;
    assign w_pabs   = r3_p[2*W-1] ? -r3_p : r3_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_re   <= w_re_sum[SUMW-1:F];
        r4_im   <= w_im_sum[SUMW-1:F];
        r4_sign <= r3_p[2*W-1];
        r4_mag  <= w_pabs[2*W-3:0];
        r4_vm   <= r3_vm;
    end

    // ------------------------------------------------------------------
    // Stage 5: range check and squares
    // ------------------------------------------------------------------
    logic                  r5_vld;
    logic                  r5_over;
    logic [2*W-3:0]        r5_sq_re, r5_sq_im;
    logic                  r5_sign;
    logic [2*W-3:0]        r5_mag;
    logic signed [W-1:0]   r5_vm;
    logic signed [W-1:0]   w_re_t, w_im_t;
    logic signed [2*W-1:0] w_sq_re, w_sq_im;
    logic                  w_re_ok, w_im_ok;

    assign w_re_t  = r4_re[W-1:0];
    assign w_im_t  = r4_im[W-1:0];
    assign w_sq_re = w_re_t * w_re_t;
    assign w_sq_im = w_im_t * w_im_t;

    // A part is in range when it lies strictly inside +/- 2^(W-1).
    assign w_re_ok = (~|r4_re[RW-1:W-1]) || ((&r4_re[RW-1:W-1]) && (|r4_re[W-2:0]));
    assign w_im_ok = (~|r4_im[RW-1:W-1]) || ((&r4_im[RW-1:W-1]) && (|r4_im[W-2:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_over  <= !(w_re_ok && w_im_ok);
        r5_sq_re <= w_sq_re[2*W-3:0];
        r5_sq_im <= w_sq_im[2*W-3:0];
        r5_sign  <= r4_sign;
        r5_mag   <= r4_mag;
        r5_vm    <= r4_vm;
    end

    // ------------------------------------------------------------------
    // Stage 6: sum of squares, then the magnitude square root
    // ------------------------------------------------------------------
    logic           r6_vld;
    logic [2*W-1:0] r6_sum;
    t_pay_root      r6_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
        r6_sum      <= (2*W)'(r5_sq_re) + (2*W)'(r5_sq_im);
        r6_pay.over <= r5_over;
        r6_pay.sign <= r5_sign;
        r6_pay.mag  <= r5_mag;
        r6_pay.vm   <= r5_vm;
    end

    logic       w_s1_vld;
    logic [W-1:0] w_s1_root;
    t_pay_root  w_s1_pay;

    rvc_sqrt #(
        .IN_W  (2 * W),
        .PAY_W ($bits(t_pay_root))
    ) u_sqrt_source (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r6_vld),
        .i_value   (r6_sum),
        .i_payload (r6_pay),
        .o_valid   (w_s1_vld),
        .o_root    (w_s1_root),
        .o_payload (w_s1_pay)
    );

    // ------------------------------------------------------------------
    // Stage 7: saturate and floor VE
    // ------------------------------------------------------------------
    logic                r7_vld;
    logic [W-2:0]        r7_ve;
    logic                r7_fl;
    logic                r7_sign;
    logic [2*W-3:0]      r7_mag;
    logic signed [W-1:0] r7_vm;
    logic [W-2:0]        w_ve_pre;

    assign w_ve_pre = (w_s1_pay.over || w_s1_root[W-1]) ? SMAX_U : w_s1_root[W-2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= w_s1_vld;
        end
        // A magnitude that rounds to zero is raised to one LSB so that the
        // following division stays defined.
        r7_fl   <= (w_ve_pre == '0);
        r7_ve   <= (w_ve_pre == '0) ? (W-1)'(1) : w_ve_pre;
        r7_sign <= w_s1_pay.sign;
        r7_mag  <= w_s1_pay.mag;
        r7_vm   <= w_s1_pay.vm;
    end

    // ------------------------------------------------------------------
    // Stage 8: rounded dividend and quotient overflow check, then divide
    // ------------------------------------------------------------------
    logic             r8_vld;
    logic [2*W-2:0]   r8_num;
    logic [W-2:0]     r8_ve;
    t_pay_div         r8_pay;
    logic [2*W-2:0]   w_num;

    assign w_num = (2*W-1)'(r7_mag) + (2*W-1)'(r7_ve >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= r7_vld;
        end
        r8_num      <= w_num;
        r8_ve       <= r7_ve;
        r8_pay.ve   <= r7_ve;
        r8_pay.fl   <= r7_fl;
        r8_pay.sign <= r7_sign;
        r8_pay.ovf  <= (w_num >= {r7_ve, {W{1'b0}}});
        r8_pay.vm   <= r7_vm;
    end

    logic         w_dv_vld;
    logic [W-1:0] w_dv_quo;
    t_pay_div     w_dv_pay;

    rvc_div #(
        .QW    (W),
        .DW    (W - 1),
        .PAY_W ($bits(t_pay_div))
    ) u_div_load (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r8_vld),
        .i_num      (r8_num),
        .i_den      (r8_ve),
        .i_payload  (r8_pay),
        .o_valid    (w_dv_vld),
        .o_quotient (w_dv_quo),
        .o_payload  (w_dv_pay)
    );

    // ------------------------------------------------------------------
    // Stage 9: signed and saturated normalised load current
    // ------------------------------------------------------------------
    logic                r9_vld;
    logic signed [W-1:0] r9_inl;
    logic [W-2:0]        r9_ve;
    logic                r9_fl;
    logic signed [W-1:0] r9_vm;
    logic                w_q_sat;

    assign w_q_sat = w_dv_pay.ovf || w_dv_quo[W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else begin
            r9_vld <= w_dv_vld;
        end
        if (w_q_sat) begin
            r9_inl <= w_dv_pay.sign ? SMIN_S : SMAX_S;
        end else if (w_dv_pay.sign) begin
            r9_inl <= -$signed(w_dv_quo);
        end else begin
            r9_inl <= $signed(w_dv_quo);
        end
        r9_ve <= w_dv_pay.ve;
        r9_fl <= w_dv_pay.fl;
        r9_vm <= w_dv_pay.vm;
    end

    // ------------------------------------------------------------------
    // Stage 10: curve segment and the products of every segment
    // ------------------------------------------------------------------
    logic                r10_vld;
    t_fex_seg            r10_seg;
    logic [2*F-1:0]      r10_p577;
    logic [2*F-1:0]      r10_sq;
    logic [2*F+1:0]      r10_p1732;
    logic [W-2:0]        r10_ve;
    logic                r10_fl;
    logic signed [W-1:0] r10_inl;
    logic signed [W-1:0] r10_vm;
    t_fex_seg            w_seg;
    logic [W-2:0]        w_in_u;
    logic [F:0]          w_one_minus;

    assign w_in_u      = r9_inl[W-2:0];
    assign w_one_minus = FEX_ONE - r9_inl[F:0];

    // The boundary at 0.433 belongs to the linear segment.
    always_comb begin
        if (r9_inl[W-1] || (r9_inl == '0)) begin
            w_seg = SEG_ONE;
        end else if (w_in_u <= (W-1)'(C_0433)) begin
            w_seg = SEG_LINEAR;
        end else if (w_in_u < (W-1)'(C_075)) begin
            w_seg = SEG_ROOT;
        end else if (w_in_u <= (W-1)'(FEX_ONE)) begin
            w_seg = SEG_FALL;
        end else begin
            w_seg = SEG_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else begin
            r10_vld <= r9_vld;
        end
        r10_seg   <= w_seg;
        r10_p577  <= (2*F)'(C_0577) * (2*F)'(r9_inl[F-1:0]);
        r10_sq    <= (2*F)'(r9_inl[F-1:0]) * (2*F)'(r9_inl[F-1:0]);
        r10_p1732 <= (2*F+2)'(C_1732) * (2*F+2)'(w_one_minus);
        r10_ve    <= r9_ve;
        r10_fl    <= r9_fl;
        r10_inl   <= r9_inl;
        r10_vm    <= r9_vm;
    end

    // ------------------------------------------------------------------
    // Stage 11: segment values, then the square root segment
    // ------------------------------------------------------------------
    logic           r11_vld;
    logic [2*F-1:0] r11_rad;
    t_pay_fex       r11_pay;
    logic [2*F-1:0] w_p577_r;
    logic [2*F+1:0] w_p1732_r;

    assign w_p577_r  = r10_p577 + HALF_2F;
    assign w_p1732_r = r10_p1732 + HALF_2F2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_vld <= 1'b0;
        end else begin
            r11_vld <= r10_vld;
        end
        r11_rad      <= {C_075, {F{1'b0}}} - r10_sq;
        r11_pay.seg  <= r10_seg;
        r11_pay.lin  <= FEX_ONE - {1'b0, w_p577_r[2*F-1:F]};
        r11_pay.fall <= w_p1732_r[2*F:F];
        r11_pay.ve   <= r10_ve;
        r11_pay.fl   <= r10_fl;
        r11_pay.inl  <= r10_inl;
        r11_pay.vm   <= r10_vm;
    end

    logic         w_s2_vld;
    logic [F-1:0] w_s2_root;
    t_pay_fex     w_s2_pay;

    rvc_sqrt #(
        .IN_W  (2 * F),
        .PAY_W ($bits(t_pay_fex))
    ) u_sqrt_fex (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r11_vld),
        .i_value   (r11_rad),
        .i_payload (r11_pay),
        .o_valid   (w_s2_vld),
        .o_root    (w_s2_root),
        .o_payload (w_s2_pay)
    );

    // ------------------------------------------------------------------
    // Stage 12: select FEX and multiply by VE
    // ------------------------------------------------------------------
    logic                r12_vld;
    logic [W+F-1:0]      r12_prod;
    logic [F:0]          r12_fex;
    logic [W-2:0]        r12_ve;
    logic                r12_fl;
    logic signed [W-1:0] r12_inl;
    logic signed [W-1:0] r12_vm;
    logic [F:0]          w_fex;

    always_comb begin
        case (w_s2_pay.seg)
            SEG_ONE:    w_fex = FEX_ONE;
            SEG_LINEAR: w_fex = w_s2_pay.lin;
            SEG_ROOT:   w_fex = {1'b0, w_s2_root};
            SEG_FALL:   w_fex = w_s2_pay.fall;
            default:    w_fex = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_vld <= 1'b0;
        end else begin
            r12_vld <= w_s2_vld;
        end
        r12_prod <= (W+F)'(w_s2_pay.ve) * (W+F)'(w_fex);
        r12_fex  <= w_fex;
        r12_ve   <= w_s2_pay.ve;
        r12_fl   <= w_s2_pay.fl;
        r12_inl  <= w_s2_pay.inl;
        r12_vm   <= w_s2_pay.vm;
    end

    // ------------------------------------------------------------------
    // Stage 13: rounded VB, limited to VBMAX
    // ------------------------------------------------------------------
    logic                r13_vld;
    logic [W-2:0]        r13_vb;
    logic [F:0]          r13_fex;
    logic [W-2:0]        r13_ve;
    logic                r13_fl;
    logic signed [W-1:0] r13_inl;
    logic signed [W-1:0] r13_vm;
    logic [W+F-1:0]      w_vb_sum;

    assign w_vb_sum = r12_prod + HALF_WF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r13_vld <= 1'b0;
        end else begin
            r13_vld <= r12_vld;
        end
        if (w_vb_sum[W+F-1:F] > W'(r_vbmax)) begin
            r13_vb <= r_vbmax;
        end else begin
            r13_vb <= w_vb_sum[W+F-2:F];
        end
        r13_fex <= r12_fex;
        r13_ve  <= r12_ve;
        r13_fl  <= r12_fl;
        r13_inl <= r12_inl;
        r13_vm  <= r12_vm;
    end

    // ------------------------------------------------------------------
    // Stage 14: field voltage product
    // ------------------------------------------------------------------
    logic                  r14_vld;
    logic signed [2*W-1:0] r14_e;
    logic [W-2:0]          r14_vb;
    logic [F:0]            r14_fex;
    logic [W-2:0]          r14_ve;
    logic                  r14_fl;
    logic signed [W-1:0]   r14_inl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r14_vld <= 1'b0;
        end else begin
            r14_vld <= r13_vld;
        end
        r14_e   <= $signed({1'b0, r13_vb}) * r13_vm;
        r14_vb  <= r13_vb;
        r14_fex <= r13_fex;
        r14_ve  <= r13_ve;
        r14_fl  <= r13_fl;
        r14_inl <= r13_inl;
    end

    // ------------------------------------------------------------------
    // Stage 15: rounded and saturated field voltage; result registers
    // ------------------------------------------------------------------
    logic                r15_vld;
    logic [W-2:0]        r15_ve;
    logic                r15_fl;
    logic signed [W-1:0] r15_inl;
    logic [F:0]          r15_fex;
    logic [W-2:0]        r15_vb;
    logic signed [W-1:0] r15_efd;
    logic signed [2*W-1:0] w_efd_sum;
    logic [2*W-F-1:0]    w_efd_r;
    logic                w_efd_ok;

    assign w_efd_sum = r14_e + HALF_2W;
    assign w_efd_r   = w_efd_sum[2*W-1:F];
    assign w_efd_ok  = (~|w_efd_r[2*W-F-1:W-1]) || (&w_efd_r[2*W-F-1:W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r15_vld <= 1'b0;
        end else begin
            r15_vld <= r14_vld;
        end
        if (w_efd_ok) begin
            r15_efd <= w_efd_r[W-1:0];
        end else begin
            r15_efd <= w_efd_r[2*W-F-1] ? SMIN_S : SMAX_S;
        end
        r15_ve  <= r14_ve;
        r15_fl  <= r14_fl;
        r15_inl <= r14_inl;
        r15_fex <= r14_fex;
        r15_vb  <= r14_vb;
    end

    assign o_done                    = r15_vld;
    assign o_source_voltage          = r15_ve;
    assign o_source_floored          = r15_fl;
    assign o_normalized_load_current = r15_inl;
    assign o_commutation_factor      = r15_fex;
    assign o_bridge_voltage          = r15_vb;
    assign o_field_voltage           = r15_efd;

endmodule

/* tb/sv/rectifier_voltage_commutation_checker.sv */
module rectifier_voltage_commutation_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic                       i_done,
    input  logic                       i_cfg_we,
    input  rvc_pkg::t_cfg_index        i_cfg_index,
    input  logic [23:0]                i_cfg_data,
    input  logic signed [23:0]         i_voltage_direct,
    input  logic signed [23:0]         i_voltage_quadrature,
    input  logic signed [23:0]         i_current_direct,
    input  logic signed [23:0]         i_current_quadrature,
    input  logic signed [23:0]         i_field_current,
    input  logic signed [23:0]         i_inner_regulator_output,
    input  logic [22:0]                i_source_voltage,
    input  logic                       i_source_floored,
    input  logic signed [23:0]         i_normalized_load_current,
    input  logic [16:0]                i_commutation_factor,
    input  logic [22:0]                i_bridge_voltage,
    input  logic signed [23:0]         i_field_voltage,
    output int                         o_fail_count,
    output int                         o_pending
);
    import rvc_pkg::*;

    localparam int     FRAC   = 16;
    localparam longint ONE_Q  = 64'sd1 <<< FRAC;
    localparam longint S_MAX  = (64'sd1 <<< 23) - 1;
    localparam longint S_MIN  = -(64'sd1 <<< 23);
    localparam longint K_0433 = ((433 <<< FRAC) + 500) / 1000;
    localparam longint K_0577 = ((577 <<< FRAC) + 500) / 1000;
    localparam longint K_075  = (3 <<< FRAC) / 4;
    localparam longint K_1732 = ((1732 <<< FRAC) + 500) / 1000;

    typedef struct packed {
        logic [22:0] ve;
        logic        floored;
        logic [23:0] load_current;
        logic [16:0] fex;
        logic [22:0] vb;
        logic [23:0] efd;
    } t_rect_result;

    longint gain_re, gain_im, gain_i, reactance, kc, vb_limit;
    t_rect_result rect_expected[$];
    int mismatches;

    function automatic longint round_q(longint v);
        return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint unsigned root_near(longint unsigned v);
        longint unsigned r, bit_w, x;
        r = 0;
        bit_w = 64'd1 << 62;
        x = v;
        while (bit_w > x) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (x >= r + bit_w) begin
                x = x - (r + bit_w);
                r = (r >> 1) + bit_w;
            end else begin
                r = r >> 1;
            end
            bit_w = bit_w >> 2;
        end
        if (v - r * r > r) r++;
        return r;
    endfunction

    function automatic longint sat24(longint v);
        return (v > S_MAX) ? S_MAX : ((v < S_MIN) ? S_MIN : v);
    endfunction

    // Piecewise loading curve: flat, linear, circular arc, falling line, zero.
    function automatic longint fex_curve(longint load);
        longint v;
        if (load <= 0) return ONE_Q;
        if (load <= K_0433) return ONE_Q - round_q(K_0577 * load);
        if (load < K_075) begin
            v = (K_075 <<< FRAC) - load * load;
            return (v > 0) ? longint'(root_near(v)) : 0;
        end
        if (load <= ONE_Q) return round_q(K_1732 * (ONE_Q - load));
        return 0;
    endfunction

    function automatic t_rect_result rectifier_output(longint vd, longint vq, longint id,
                                                      longint iq, longint ifd, longint vm);
        t_rect_result res;
        longint kx_re, kx_im, keff, re, im, ve, p, load, fex, vb;
        longint unsigned mag, q;
        bit floored;
        kx_re = round_q(gain_re * reactance);
        kx_im = round_q(gain_im * reactance);
        keff  = gain_i + kx_re;
        re = round_q(gain_re * vd - gain_im * vq - keff * iq - kx_im * id);
        im = round_q(gain_im * vd + gain_re * vq + keff * id - kx_im * iq);
        floored = 1'b0;
        if (re > S_MAX || re < -S_MAX || im > S_MAX || im < -S_MAX) begin
            ve = S_MAX;
        end else begin
            ve = longint'(root_near(longint'(re * re + im * im)));
            if (ve > S_MAX) ve = S_MAX;
        end
        if (ve < 1) begin
            ve = 1;
            floored = 1'b1;
        end
        p = kc * ifd;
        mag = (p < 0) ? -p : p;
        q = (mag + (ve >> 1)) / ve;
        if (q > (64'd1 << 23)) q = 64'd1 << 23;
        load = sat24((p < 0) ? -longint'(q) : longint'(q));
        fex = fex_curve(load);
        vb = round_q(ve * fex);
        if (vb > vb_limit) vb = vb_limit;
        if (vb < 0) vb = 0;
        res.ve = ve[22:0];
        res.floored = floored;
        res.load_current = load[23:0];
        res.fex = fex[16:0];
        res.vb = vb[22:0];
        res.efd = 24'(sat24(round_q(vm * vb)));
        return res;
    endfunction

    task automatic report_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            o_fail_count++;
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH %s: expected %0d (0x%0h), got %0d (0x%0h)",
                         name, exp_v, exp_v, act_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_rect_result exp_r;
        if (!i_rst_n) begin
            o_fail_count = 0;
            mismatches = 0;
            gain_re  = ONE_Q;
            gain_im  = 0;
            gain_i   = 0;
            reactance = 0;
            kc       = 0;
            vb_limit = 10 <<< FRAC;
        end else begin
            // Results are compared before the new transfer is predicted.
            if (i_done) begin
                if (rect_expected.size() == 0) begin
                    o_fail_count++;
                    mismatches++;
                    if (mismatches <= 10) $display("MISMATCH: result with nothing expected");
                end else begin
                    exp_r = rect_expected.pop_front();
                    report_field("source_voltage", exp_r.ve, i_source_voltage);
                    report_field("source_floored", exp_r.floored, i_source_floored);
                    report_field("normalized_load_current",
                                 $signed(exp_r.load_current), i_normalized_load_current);
                    report_field("commutation_factor", exp_r.fex, i_commutation_factor);
                    report_field("bridge_voltage", exp_r.vb, i_bridge_voltage);
                    report_field("field_voltage", $signed(exp_r.efd), i_field_voltage);
                end
            end
            if (i_start && !i_busy)
                rect_expected.push_back(rectifier_output(
                    i_voltage_direct, i_voltage_quadrature, i_current_direct,
                    i_current_quadrature, i_field_current, i_inner_regulator_output));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SOURCE_GAIN_REAL:        gain_re   = $signed(i_cfg_data);
                    CFG_SOURCE_GAIN_IMAG:        gain_im   = $signed(i_cfg_data);
                    CFG_CURRENT_GAIN:            gain_i    = $signed(i_cfg_data);
                    CFG_LEAKAGE_REACTANCE:       reactance = $signed(i_cfg_data);
                    CFG_COMMUTATION_FACTOR_GAIN: kc        = i_cfg_data[22:0];
                    CFG_BRIDGE_VOLTAGE_LIMIT:    vb_limit  = i_cfg_data[22:0];
                    default: ;
                endcase
            end
        end
        o_pending = rect_expected.size();
    end

endmodule

/* tb/sv/rectifier_voltage_commutation_test.sv */
// Stimulus and verdict for the rectifier voltage block. The checker beside
// the block predicts every result and counts failures; this module only
// produces transfers, configuration phases and the final verdict.
module rectifier_voltage_commutation_test;
    import rvc_pkg::*;

    // Register indexes the block does not decode; writes to them must be ignored.
    localparam t_cfg_index CFG_SPARE_LOW  = 3'd6;
    localparam t_cfg_index CFG_SPARE_HIGH = 3'd7;
    localparam int NUM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 141;
    localparam int DRAIN_CYCLES = 100;

    logic i_clk, i_rst_n, start, busy, o_done;
    logic i_cfg_we;
    t_cfg_index i_cfg_index;
    logic [23:0] i_cfg_data;
    logic signed [23:0] vd, vq, id, iq, ifd, vm;
    logic [22:0] o_source_voltage, o_bridge_voltage;
    logic o_source_floored;
    logic signed [23:0] o_normalized_load_current, o_field_voltage;
    logic [16:0] o_commutation_factor;
    int fail_count, pending, items_sent, cfg_writes, total_fail;
    bit no_gaps;

    rectifier_voltage_commutation u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_done(o_done),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_voltage_direct(vd), .i_voltage_quadrature(vq),
        .i_current_direct(id), .i_current_quadrature(iq),
        .i_field_current(ifd), .i_inner_regulator_output(vm),
        .o_source_voltage(o_source_voltage), .o_source_floored(o_source_floored),
        .o_normalized_load_current(o_normalized_load_current),
        .o_commutation_factor(o_commutation_factor),
        .o_bridge_voltage(o_bridge_voltage), .o_field_voltage(o_field_voltage)
    );

    rectifier_voltage_commutation_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_done(o_done),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_voltage_direct(vd), .i_voltage_quadrature(vq),
        .i_current_direct(id), .i_current_quadrature(iq),
        .i_field_current(ifd), .i_inner_regulator_output(vm),
        .i_source_voltage(o_source_voltage), .i_source_floored(o_source_floored),
        .i_normalized_load_current(o_normalized_load_current),
        .i_commutation_factor(o_commutation_factor),
        .i_bridge_voltage(o_bridge_voltage), .i_field_voltage(o_field_voltage),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The block is pipelined and should finish well inside this bound.
    initial begin
        #3000000;
        $display("Timeout: results still outstanding");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // A signed value spread evenly over plus and minus span.
    function automatic logic signed [23:0] around_zero(int span);
        return 24'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // Mostly no pause, sometimes a short one, now and then a long one.
    task automatic idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 65) return;
        if (pick < 93) repeat ($urandom_range(1, 4)) @(negedge i_clk);
        else repeat ($urandom_range(10, 70)) @(negedge i_clk);
    endtask

    // One transfer: fields change at the falling edge, acceptance is seen
    // at a rising edge with busy low. start stays high between transfers
    // that follow each other without a gap.
    task automatic send_item(logic signed [23:0] a, logic signed [23:0] b,
                             logic signed [23:0] c, logic signed [23:0] d,
                             logic signed [23:0] e, logic signed [23:0] f);
        vd = a; vq = b; id = c; iq = d; ifd = e; vm = f;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        items_sent++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Burst-friendly variant: leaves start low only when a gap follows.
    task automatic send_random();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            // Plausible operating points: voltages within two per unit and
            // field current spread across all segments of the loading curve.
            send_item(around_zero(131072), around_zero(131072), around_zero(98304),
                      around_zero(98304), around_zero(196608), around_zero(262144));
        end else begin
            send_item(24'($urandom), 24'($urandom), 24'($urandom),
                      24'($urandom), 24'($urandom), 24'($urandom));
        end
        idle_gap();
    endtask

    task automatic write_reg(t_cfg_index idx, logic [23:0] value);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cfg_writes++;
    endtask

    // Registers change only once the pipeline has drained.
    task automatic wait_idle();
        while (pending != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    task automatic load_settings(logic [23:0] kre, logic [23:0] kim, logic [23:0] ki,
                                 logic [23:0] xl, logic [23:0] kc, logic [23:0] vbmax);
        wait_idle();
        write_reg(CFG_SOURCE_GAIN_REAL, kre);
        write_reg(CFG_SOURCE_GAIN_IMAG, kim);
        write_reg(CFG_CURRENT_GAIN, ki);
        write_reg(CFG_LEAKAGE_REACTANCE, xl);
        // The top bit of the two unsigned registers is random and must be ignored.
        write_reg(CFG_COMMUTATION_FACTOR_GAIN, {1'($urandom), kc[22:0]});
        write_reg(CFG_BRIDGE_VOLTAGE_LIMIT, {1'($urandom), vbmax[22:0]});
        write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_LOW : CFG_SPARE_HIGH,
                  24'($urandom));
    endtask

    initial begin
        int ifd_points[10];
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_SOURCE_GAIN_REAL;
        i_cfg_data = '0;
        vd = '0; vq = '0; id = '0; iq = '0; ifd = '0; vm = '0;
        items_sent = 0;
        cfg_writes = 0;
        no_gaps = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed, settings as after reset: zero source (floored), both
        // extremes of every field, and saturation of the source voltage.
        send_item(0, 0, 0, 0, 0, 0);
        send_item(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
        send_item(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
        send_item(24'h800000, 0, 0, 0, 0, 24'h7fffff);
        send_item(0, 24'h7fffff, 0, 0, 0, 24'h800000);

        // Directed, unit source voltage and unit loading gain, so that the
        // field current walks across every segment boundary of the curve,
        // including the point 0.433 itself and the ends of the arc.
        load_settings(24'd65536, 0, 0, 0, 24'd65536, 24'd655360);
        ifd_points = '{-65536, 0, 1, 28376, 28377, 28378, 49151, 49152, 65536, 65537};
        foreach (ifd_points[i])
            send_item(24'd65536, 0, 0, 0, 24'(ifd_points[i]), 24'd65536);
        send_item(24'd65536, 0, 0, 0, 24'h7fffff, 24'h7fffff);
        send_item(24'd1, 0, 0, 0, 24'h7fffff, 24'h7fffff);
        send_item(24'd1, 0, 0, 0, 24'h800000, 24'h800000);
        send_item(24'h7fffff, 0, 0, 0, 24'd1, 24'h7fffff);
        send_item(24'h7fffff, 0, 0, 0, 0, 24'h800000);

        // Random phases over a spread of settings, the extremes among them.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: load_settings(24'd65536, 0, 0, 0, 24'd0, 24'd655360);
                1: load_settings(24'd46341, 24'd46341, 24'd19661, 24'd13107,
                                 24'd39322, 24'd327680);
                2: load_settings(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff,
                                 24'h7fffff, 24'h7fffff);
                3: load_settings(24'h800000, 24'h800000, 24'h800000, 24'h800000,
                                 24'd0, 24'd0);
                4: load_settings(24'($urandom), 24'($urandom), 24'($urandom),
                                 24'($urandom), 24'($urandom), 24'($urandom));
                5: load_settings(around_zero(98304), around_zero(98304),
                                 around_zero(65536), around_zero(32768),
                                 24'($urandom_range(0, 131072)),
                                 24'($urandom_range(0, 1048576)));
                6: load_settings(24'd65536, 24'hffff00, 24'd6554, 24'd9830,
                                 24'd65536, 24'd98304);
                default: load_settings(around_zero(131072), around_zero(131072),
                                       around_zero(131072), around_zero(65536),
                                       24'($urandom_range(0, 196608)),
                                       24'($urandom_range(0, 8388607)));
            endcase
            no_gaps = (ph % 3 == 1);
            repeat (ITEMS_PER_PHASE) send_random();
        end

        // Drain, then allow a pipeline's worth of extra cycles for strays.
        for (int n = 0; n < 4000 && pending != 0; n++) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        total_fail = fail_count + ((pending != 0) ? 1 : 0);
        if (pending != 0) $display("%0d expected results never arrived", pending);

        $display("Sent %0d transfers over %0d settings phases with %0d register writes,",
                 items_sent, NUM_PHASES + 2, cfg_writes);
        $display("covering every loading segment, floored and saturated sources.");
        if (total_fail == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d failures", total_fail);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
